FILE: src/dmcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dmcs_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MAIL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_END = 1'b1;

  localparam logic [WORD_W-1:0] SYNC_MAIL_RESET = 32'hDCD1_0004;
  localparam logic [WORD_W-1:0] FRAME_END_RESET = 32'hDCD1_0005;

  localparam logic [WORD_W-1:0] IGNORED_MAIL   = 32'hCDD1_0003;
  localparam logic [WORD_W-1:0] BUFFER_REPORT  = 32'hF355_FF00;
  localparam logic [WORD_W-1:0] COMMAND_REPORT = 32'hF355_0000;

  localparam logic [6:0] CMD_SET_VOICES  = 7'h01;
  localparam logic [6:0] CMD_SET_BUFFERS = 7'h02;

  // One reply group: sync mail, then the report word, then an optional frame-end mail.
  typedef struct packed {
    logic [WORD_W-1:0] report;
    logic              frame_end;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_push_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SYNC,
    BK_REPORT,
    BK_FRAME
  } back_state_e;

endpackage
`default_nettype wire

FILE: src/dmcs_front.sv
`timescale 1ns / 1ps
`default_nettype none
module dmcs_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      accept_i,
  input  wire logic [dmcs_pkg::WORD_W-1:0] mail_word_i,
  output dmcs_pkg::job_push_t            push_o
);

  logic        sync_pending_q, sync_pending_d;
  logic        collecting_q, collecting_d;
  logic [7:0]  word_target_q, word_target_d;
  logic [7:0]  word_count_q, word_count_d;
  logic [6:0]  kind_q, kind_d;
  logic [31:0] first_word_q, first_word_d;
  logic [15:0] voice_total_q, voice_total_d;
  logic [6:0]  buffer_total_q, buffer_total_d;
  logic [31:0] buffer_index_q, buffer_index_d;

  logic [4:0]  limit_hi;
  logic [8:0]  limit;
  logic [31:0] index_inc;
  logic [7:0]  count_inc;
  logic [31:0] fw_eff;
  logic [6:0]  kind_eff;
  logic        frame_done;

  always_comb begin
    sync_pending_d = sync_pending_q;
    collecting_d   = collecting_q;
    word_target_d  = word_target_q;
    word_count_d   = word_count_q;
    kind_d         = kind_q;
    first_word_d   = first_word_q;
    voice_total_d  = voice_total_q;
    buffer_total_d = buffer_total_q;
    buffer_index_d = buffer_index_q;
    push_o         = '0;

    limit_hi   = {1'b0, mail_word_i[19:16]} + 5'd1;
    limit      = {limit_hi, 4'b0000};
    index_inc  = buffer_index_q + 32'd1;
    frame_done = (index_inc == {25'b0, buffer_total_q});
    count_inc  = word_count_q + 8'd1;
    fw_eff     = (word_count_q == 8'd0) ? mail_word_i : first_word_q;
    kind_eff   = (word_count_q == 8'd0) ? mail_word_i[30:24] : kind_q;

    if (accept_i) begin
      if (sync_pending_q) begin
        sync_pending_d = 1'b0;
        if ({7'b0, limit} >= voice_total_q) begin
          push_o.valid         = 1'b1;
          push_o.job.report    = dmcs_pkg::BUFFER_REPORT | index_inc;
          push_o.job.frame_end = frame_done;
          buffer_index_d       = frame_done ? 32'd0 : index_inc;
        end
      end else if (mail_word_i == '0) begin
        sync_pending_d = 1'b1;
      end else if (mail_word_i == dmcs_pkg::IGNORED_MAIL) begin
        sync_pending_d = 1'b0;
      end else if (!collecting_q) begin
        word_target_d = mail_word_i[7:0];
        word_count_d  = 8'd0;
        collecting_d  = 1'b1;
      end else if (word_count_q < word_target_q) begin
        if (word_count_q == 8'd0) begin
          kind_d       = mail_word_i[30:24];
          first_word_d = mail_word_i;
        end
        word_count_d = count_inc;
        if (count_inc == word_target_q) begin
          if (kind_eff == dmcs_pkg::CMD_SET_VOICES) begin
            voice_total_d = fw_eff[15:0];
          end else if (kind_eff == dmcs_pkg::CMD_SET_BUFFERS) begin
            buffer_total_d = fw_eff[22:16];
            buffer_index_d = 32'd0;
          end
          push_o.valid         = 1'b1;
          push_o.job.report    = dmcs_pkg::COMMAND_REPORT | {16'b0, fw_eff[31:16]};
          push_o.job.frame_end = 1'b0;
          word_target_d        = 8'd0;
          kind_d               = 7'd0;
          collecting_d         = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_pending_q <= 1'b0;
      collecting_q   <= 1'b0;
      word_target_q  <= '0;
      word_count_q   <= '0;
      kind_q         <= '0;
      voice_total_q  <= '0;
      buffer_total_q <= '0;
      buffer_index_q <= '0;
    end else begin
      sync_pending_q <= sync_pending_d;
      collecting_q   <= collecting_d;
      word_target_q  <= word_target_d;
      word_count_q   <= word_count_d;
      kind_q         <= kind_d;
      voice_total_q  <= voice_total_d;
      buffer_total_q <= buffer_total_d;
      buffer_index_q <= buffer_index_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_word_q <= first_word_d;
  end

endmodule
`default_nettype wire

FILE: src/dmcs_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module dmcs_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dmcs_pkg::job_push_t push_i,
  output logic                     full_o,
  output logic                     valid_o,
  output dmcs_pkg::job_t           head_o,
  input  wire logic                pop_i
);

  dmcs_pkg::job_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    do_push  = push_i.valid && !full_o;
    do_pop   = pop_i && valid_o;
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_i.job;
    end
  end

endmodule
`default_nettype wire

FILE: src/dmcs_back.sv
`timescale 1ns / 1ps
`default_nettype none
module dmcs_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_write_i,
  input  wire logic [dmcs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [dmcs_pkg::WORD_W-1:0]    cfg_data_i,
  input  wire logic                          job_valid_i,
  input  wire dmcs_pkg::job_t                job_i,
  output logic                               pop_o,
  output logic                               reply_valid_o,
  input  wire logic                          reply_ready_i,
  output logic [dmcs_pkg::WORD_W-1:0]         reply_word_o,
  output logic                               raise_interrupt_o,
  output logic                               last_reply_o
);

  dmcs_pkg::back_state_e        state_q, state_d;
  dmcs_pkg::job_t               job_q;
  logic [dmcs_pkg::WORD_W-1:0]  sync_mail_q;
  logic [dmcs_pkg::WORD_W-1:0]  frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_mail_q <= dmcs_pkg::SYNC_MAIL_RESET;
      frame_end_q <= dmcs_pkg::FRAME_END_RESET;
    end else if (cfg_write_i) begin
      case (cfg_index_i)
        dmcs_pkg::CFG_SYNC_MAIL: sync_mail_q <= cfg_data_i;
        dmcs_pkg::CFG_FRAME_END: frame_end_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d           = state_q;
    pop_o             = 1'b0;
    reply_valid_o     = 1'b1;
    reply_word_o      = sync_mail_q;
    raise_interrupt_o = 1'b0;
    last_reply_o      = 1'b0;
    case (state_q)
      dmcs_pkg::BK_IDLE: begin
        reply_valid_o = 1'b0;
        if (job_valid_i) begin
          pop_o   = 1'b1;
          state_d = dmcs_pkg::BK_SYNC;
        end
      end
      dmcs_pkg::BK_SYNC: begin
        raise_interrupt_o = 1'b1;
        if (reply_ready_i) begin
          state_d = dmcs_pkg::BK_REPORT;
        end
      end
      dmcs_pkg::BK_REPORT: begin
        reply_word_o = job_q.report;
        last_reply_o = !job_q.frame_end;
        if (reply_ready_i) begin
          if (job_q.frame_end) begin
            state_d = dmcs_pkg::BK_FRAME;
          end else if (job_valid_i) begin
            pop_o   = 1'b1;
            state_d = dmcs_pkg::BK_SYNC;
          end else begin
            state_d = dmcs_pkg::BK_IDLE;
          end
        end
      end
      dmcs_pkg::BK_FRAME: begin
        reply_word_o = frame_end_q;
        last_reply_o = 1'b1;
        if (reply_ready_i) begin
          if (job_valid_i) begin
            pop_o   = 1'b1;
            state_d = dmcs_pkg::BK_SYNC;
          end else begin
            state_d = dmcs_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        reply_valid_o = 1'b0;
        state_d       = dmcs_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmcs_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
  end

endmodule
`default_nettype wire

FILE: src/dsp_mailbox_command_sync.sv
// Mailbox command and sync handler of an audio DSP.
// Mail words from the host arrive on the mail channel (mail_valid_i, mail_ready_o,
// mail_word_i). A front stage decodes each word, updates the command and buffer
// state and, when the word calls for replies, queues one reply group. A back
// sequencer sends each group on the reply channel as a sync mail with interrupt,
// a report word and, at the end of a frame, a frame-end mail; last_reply_o marks
// the final reply of the group.
// Mail is accepted one word per cycle while the two-entry reply queue has room.
// When the back sequencer is idle, the first reply of a group is valid once the group
// has passed the reply queue and the sequencer's state register. The sequencer sends
// one reply per cycle while the receiver is ready, with no gap between queued groups.
// When the receiver stalls, the current reply holds; once the queue fills,
// mail_ready_o drops until the back sequencer takes the next group.
// The two mail codes are written on the configuration channel (index 0: sync
// mail, index 1: frame-end mail), by the user only while the block is idle; the block
// leaves this to the user and always accepts. Reset clears the sync and buffer state and
// the command counters and kind, empties the queue and loads the default mail codes.
`timescale 1ns / 1ps
`default_nettype none
module dsp_mailbox_command_sync (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          mail_valid_i,
  output logic                               mail_ready_o,
  input  wire logic [dmcs_pkg::WORD_W-1:0]    mail_word_i,
  output logic                               reply_valid_o,
  input  wire logic                          reply_ready_i,
  output logic [dmcs_pkg::WORD_W-1:0]         reply_word_o,
  output logic                               raise_interrupt_o,
  output logic                               last_reply_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [dmcs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [dmcs_pkg::WORD_W-1:0]    cfg_data_i
);

  dmcs_pkg::job_push_t push;
  dmcs_pkg::job_t      head;
  logic                full;
  logic                head_valid;
  logic                pop;

  assign mail_ready_o = !full;
  assign cfg_ready_o  = 1'b1;

  dmcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (mail_valid_i && mail_ready_o),
    .mail_word_i (mail_word_i),
    .push_o      (push)
  );

  dmcs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .valid_o (head_valid),
    .head_o  (head),
    .pop_i   (pop)
  );

  dmcs_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_write_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .job_valid_i       (head_valid),
    .job_i             (head),
    .pop_o             (pop),
    .reply_valid_o     (reply_valid_o),
    .reply_ready_i     (reply_ready_i),
    .reply_word_o      (reply_word_o),
    .raise_interrupt_o (raise_interrupt_o),
    .last_reply_o      (last_reply_o)
  );

endmodule
`default_nettype wire

FILE: src/dmcs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module dmcs_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          reply_valid_o,
  input wire logic                          reply_ready_i,
  input wire logic [dmcs_pkg::WORD_W-1:0]    reply_word_o,
  input wire logic                          raise_interrupt_o,
  input wire logic                          last_reply_o
);

  // A pending reply transaction holds until the receiver takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_valid_o && !reply_ready_i |=> reply_valid_o)
    else $error("reply transaction dropped while stalled");

  // The sync mail never closes a reply group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_valid_o && raise_interrupt_o |-> !last_reply_o)
    else $error("sync mail marked as last reply");

  // A sync mail is always followed by a status report word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_valid_o && reply_ready_i && raise_interrupt_o |=>
      reply_valid_o && !raise_interrupt_o && (reply_word_o[31:16] == 16'hF355))
    else $error("sync mail not followed by a report word");

  // A reply group that is not finished continues in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_valid_o && reply_ready_i && !last_reply_o |=> reply_valid_o)
    else $error("reply group cut short");

endmodule

bind dsp_mailbox_command_sync dmcs_checker u_dmcs_checker (.*);
`default_nettype wire

FILE: dv/dsp_mailbox_command_sync_test.sv
`timescale 1ns / 1ps
module dsp_mailbox_command_sync_test;

  localparam int NOT_TYPED = -1;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [dmcs_pkg::WORD_W-1:0]      mail;
    int                               count;
    logic [2:0][dmcs_pkg::WORD_W-1:0] word;
  } stim_row_t;

  typedef struct packed {
    logic [dmcs_pkg::WORD_W-1:0] word;
    logic                        irq;
    logic                        last;
  } reply_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           mail_valid = 1'b0;
  logic [dmcs_pkg::WORD_W-1:0]    mail_word = '0;
  logic                           reply_ready = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic [dmcs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dmcs_pkg::WORD_W-1:0]    cfg_data = '0;
  logic                           mail_ready_o;
  logic                           reply_valid_o;
  logic [dmcs_pkg::WORD_W-1:0]    reply_word_o;
  logic                           raise_interrupt_o;
  logic                           last_reply_o;
  logic                           cfg_ready_o;

  logic [dmcs_pkg::WORD_W-1:0] sync_code = dmcs_pkg::SYNC_MAIL_RESET;
  logic [dmcs_pkg::WORD_W-1:0] frame_code = dmcs_pkg::FRAME_END_RESET;
  logic                        sync_armed = 1'b0;
  logic                        cmd_open = 1'b0;
  logic [7:0]                  cmd_len = '0;
  logic [7:0]                  cmd_got = '0;
  logic [6:0]                  cmd_kind = '0;
  logic [dmcs_pkg::WORD_W-1:0] cmd_head = '0;
  logic [15:0]                 voice_count = '0;
  logic [6:0]                  buf_count = '0;
  logic [dmcs_pkg::WORD_W-1:0] buf_index = '0;
  logic [dmcs_pkg::WORD_W-1:0] model_word [3];

  stim_row_t stim_rows [$];
  stim_row_t mail_rows [$];
  reply_t    replies_due [$];
  int        lockout_at;
  int        random_sent = 0;
  int        errors = 0;
  int        mails_taken = 0;
  int        replies_checked = 0;
  int        frame_ends = 0;
  int        reg_writes = 0;
  int        idle_cycles = 0;

  dsp_mailbox_command_sync u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .mail_valid_i      (mail_valid),
    .mail_ready_o      (mail_ready_o),
    .mail_word_i       (mail_word),
    .reply_valid_o     (reply_valid_o),
    .reply_ready_i     (reply_ready),
    .reply_word_o      (reply_word_o),
    .raise_interrupt_o (raise_interrupt_o),
    .last_reply_o      (last_reply_o),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int predict_mail(input logic [dmcs_pkg::WORD_W-1:0] mail);
    int                          n;
    logic [dmcs_pkg::WORD_W-1:0] lim;
    n = 0;
    if (sync_armed) begin
      sync_armed = 1'b0;
      lim = (32'(mail[19:16]) + 32'd1) << 4;
      if (lim >= 32'(voice_count)) begin
        buf_index = buf_index + 32'd1;
        model_word[0] = sync_code;
        model_word[1] = dmcs_pkg::BUFFER_REPORT | buf_index;
        n = 2;
        if (buf_index == 32'(buf_count)) begin
          model_word[2] = frame_code;
          n = 3;
          buf_index = '0;
          frame_ends++;
        end
      end
    end else if (mail == '0) begin
      sync_armed = 1'b1;
    end else if (mail == dmcs_pkg::IGNORED_MAIL) begin
    end else if (!cmd_open) begin
      cmd_len = mail[7:0];
      cmd_got = '0;
      cmd_open = 1'b1;
    end else if (cmd_got < cmd_len) begin
      if (cmd_got == 8'd0) begin
        cmd_kind = mail[30:24];
        cmd_head = mail;
      end
      cmd_got = cmd_got + 8'd1;
      if (cmd_got == cmd_len) begin
        if (cmd_kind == dmcs_pkg::CMD_SET_VOICES) begin
          voice_count = cmd_head[15:0];
        end else if (cmd_kind == dmcs_pkg::CMD_SET_BUFFERS) begin
          buf_count = cmd_head[22:16];
          buf_index = '0;
        end
        model_word[0] = sync_code;
        model_word[1] = dmcs_pkg::COMMAND_REPORT | {16'h0000, cmd_head[31:16]};
        n = 2;
        cmd_len = '0;
        cmd_kind = '0;
        cmd_open = 1'b0;
      end
    end
    return n;
  endfunction

  always @(posedge clk_i) begin : observe
    reply_t                      exp_reply;
    stim_row_t                   row;
    int                          n;
    logic [dmcs_pkg::WORD_W-1:0] w;
    if (rst_ni) begin
      if (reply_valid_o && reply_ready) begin
        replies_checked++;
        if (replies_due.size() == 0) begin
          $error("unexpected reply transaction: reply_word %h", reply_word_o);
          errors++;
        end else begin
          exp_reply = replies_due.pop_front();
          if (reply_word_o !== exp_reply.word) begin
            $error("reply_word: expected %h, actual %h", exp_reply.word, reply_word_o);
            errors++;
          end
          if (raise_interrupt_o !== exp_reply.irq) begin
            $error("raise_interrupt: expected %b, actual %b", exp_reply.irq,
                   raise_interrupt_o);
            errors++;
          end
          if (last_reply_o !== exp_reply.last) begin
            $error("last_reply: expected %b, actual %b", exp_reply.last, last_reply_o);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready_o) begin
        reg_writes++;
        if (cfg_index == dmcs_pkg::CFG_SYNC_MAIL) begin
          sync_code = cfg_data;
        end else if (cfg_index == dmcs_pkg::CFG_FRAME_END) begin
          frame_code = cfg_data;
        end
      end
      if (mail_valid && mail_ready_o) begin
        mails_taken++;
        row = mail_rows.pop_front();
        n = predict_mail(row.mail);
        if (row.count != NOT_TYPED) begin
          n = row.count;
        end
        for (int k = 0; k < n; k++) begin
          w = (row.count != NOT_TYPED) ? row.word[k] : model_word[k];
          replies_due.insert(replies_due.size(),
                             '{word: w, irq: (k == 0), last: (k == n - 1)});
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (mail_valid && mail_ready_o) || (reply_valid_o && reply_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int burst;
    int stall;
    forever begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        @(negedge clk_i);
        reply_ready <= 1'b1;
      end
      stall = pick_gap();
      repeat (stall) begin
        @(negedge clk_i);
        reply_ready <= 1'b0;
      end
    end
  end

  function automatic void add_row(input logic [dmcs_pkg::WORD_W-1:0] mail, input int count,
                                  input logic [dmcs_pkg::WORD_W-1:0] w0 = '0,
                                  input logic [dmcs_pkg::WORD_W-1:0] w1 = '0,
                                  input logic [dmcs_pkg::WORD_W-1:0] w2 = '0);
    stim_row_t row;
    row.mail = mail;
    row.count = count;
    row.word[0] = w0;
    row.word[1] = w1;
    row.word[2] = w2;
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  task automatic put_mail(input stim_row_t row);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      mail_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    mail_valid <= 1'b1;
    mail_word <= row.mail;
    mail_rows.insert(mail_rows.size(), row);
    @(posedge clk_i);
    while (!mail_ready_o) @(posedge clk_i);
    #1;
  endtask

  task automatic put_random(input logic [dmcs_pkg::WORD_W-1:0] w);
    stim_row_t row;
    if (!sync_armed && !cmd_open && w != '0 && w != dmcs_pkg::IGNORED_MAIL &&
        w[7:0] == 8'h00) begin
      w[7:0] = 8'($urandom_range(1, 255));
    end
    row.mail = w;
    row.count = NOT_TYPED;
    row.word = '0;
    put_mail(row);
    random_sent++;
  endtask

  task automatic walk_rows(input int first, input int stop);
    for (int i = first; i < stop; i++) begin
      put_mail(stim_rows[i]);
    end
  endtask

  task automatic run_random(input int items);
    int          stop;
    int          pick;
    int          r;
    int          len;
    logic [6:0]  kind;
    logic [6:0]  bufs;
    logic [15:0] low;
    stop = random_sent + items;
    while (random_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        put_random('0);
        put_random($urandom());
      end else if (pick < 75) begin
        r = $urandom_range(0, 99);
        if (r < 60) len = $urandom_range(1, 3);
        else if (r < 90) len = $urandom_range(4, 20);
        else if (r < 97) len = $urandom_range(21, 127);
        else len = $urandom_range(128, 255);
        if (len > stop - random_sent) len = stop - random_sent;
        put_random({24'($urandom()), 8'(len)});
        r = $urandom_range(0, 9);
        if (r < 4) kind = dmcs_pkg::CMD_SET_VOICES;
        else if (r < 7) kind = dmcs_pkg::CMD_SET_BUFFERS;
        else kind = 7'($urandom());
        low = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 256)) : 16'($urandom());
        bufs = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(1, 4)) : 7'($urandom());
        put_random({1'($urandom()), kind, 1'($urandom()), bufs, low});
        for (int k = 1; k < len; k++) begin
          r = $urandom_range(0, 99);
          if (r < 8) begin
            put_random('0);
            put_random($urandom());
          end else if (r < 12) begin
            put_random(dmcs_pkg::IGNORED_MAIL);
          end
          put_random($urandom());
        end
      end else if (pick < 82) begin
        put_random(dmcs_pkg::IGNORED_MAIL);
      end else begin
        put_random(($urandom_range(0, 9) < 3) ? '0 : $urandom());
      end
    end
  endtask

  task automatic close_out();
    while (sync_armed || cmd_open) put_random($urandom());
  endtask

  task automatic drain();
    @(negedge clk_i);
    mail_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [dmcs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dmcs_pkg::WORD_W-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    add_row(32'h0000_0000, 0);
    add_row(32'h0000_0000, 2, dmcs_pkg::SYNC_MAIL_RESET, dmcs_pkg::BUFFER_REPORT | 32'd1);
    add_row(dmcs_pkg::IGNORED_MAIL, 0);
    add_row(32'h0000_0003, 0);
    add_row({1'b0, dmcs_pkg::CMD_SET_BUFFERS, 8'h02, 16'h0000}, 0);
    add_row(dmcs_pkg::IGNORED_MAIL, 0);
    add_row(32'h0000_0000, 0);
    add_row(32'hFFFF_FFFF, 2, dmcs_pkg::SYNC_MAIL_RESET, dmcs_pkg::BUFFER_REPORT | 32'd2);
    add_row(32'h1234_5678, NOT_TYPED);
    add_row(32'hFFFF_FFFF, 2, dmcs_pkg::SYNC_MAIL_RESET,
            dmcs_pkg::COMMAND_REPORT | 32'h0202);
    add_row(32'h0000_0000, NOT_TYPED);
    add_row(32'h0005_0000, NOT_TYPED);
    add_row(32'h0000_0000, NOT_TYPED);
    add_row(32'h000F_0000, 3, dmcs_pkg::SYNC_MAIL_RESET, dmcs_pkg::BUFFER_REPORT | 32'd2,
            dmcs_pkg::FRAME_END_RESET);
    add_row(32'hAB00_0101, NOT_TYPED);
    add_row({1'b1, dmcs_pkg::CMD_SET_VOICES, 8'h01, 16'hFFFF}, 2,
            dmcs_pkg::SYNC_MAIL_RESET, dmcs_pkg::COMMAND_REPORT | 32'h8101);
    add_row(32'h0000_0000, NOT_TYPED);
    add_row(32'hFFFF_FFFF, 0);
    add_row(32'h0000_0001, NOT_TYPED);
    add_row(32'h7F00_ABCD, 2, dmcs_pkg::SYNC_MAIL_RESET,
            dmcs_pkg::COMMAND_REPORT | 32'h7F00);
    add_row(32'h0000_0001, NOT_TYPED);
    add_row({1'b0, dmcs_pkg::CMD_SET_VOICES, 8'h00, 16'h0040}, NOT_TYPED);
    add_row(32'h0000_0000, NOT_TYPED);
    add_row(32'h0002_0000, 0);
    add_row(32'h0000_0000, NOT_TYPED);
    add_row(32'h0003_0000, NOT_TYPED);
    lockout_at = stim_rows.size();
    add_row(32'h0000_0100, 0);
    add_row(32'h1234_5678, 0);
    add_row({1'b0, dmcs_pkg::CMD_SET_BUFFERS, 8'h05, 16'h0000}, 0);
    add_row(32'h0000_0000, NOT_TYPED);
    add_row(32'hFFFF_FFFF, NOT_TYPED);
    add_row(32'h0000_0003, 0);
    add_row(dmcs_pkg::IGNORED_MAIL, 0);
    add_row(32'h0000_0000, NOT_TYPED);
    add_row(32'h0000_0000, NOT_TYPED);
    add_row(32'hFFFF_FF01, 0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    walk_rows(0, lockout_at);
    drain();
    write_reg(dmcs_pkg::CFG_SYNC_MAIL, '0);
    write_reg(dmcs_pkg::CFG_FRAME_END, '1);
    run_random(200);
    drain();
    write_reg(dmcs_pkg::CFG_SYNC_MAIL, '1);
    write_reg(dmcs_pkg::CFG_FRAME_END, '0);
    run_random(60);
    drain();
    write_reg(dmcs_pkg::CFG_SYNC_MAIL, $urandom());
    write_reg(dmcs_pkg::CFG_FRAME_END, $urandom());
    run_random(60);
    drain();
    write_reg(dmcs_pkg::CFG_SYNC_MAIL, dmcs_pkg::SYNC_MAIL_RESET);
    write_reg(dmcs_pkg::CFG_FRAME_END, dmcs_pkg::FRAME_END_RESET);
    run_random(60);
    close_out();
    walk_rows(lockout_at, stim_rows.size());
    drain();

    $display("Covered %0d mail and %0d reply transactions with %0d frame ends.",
             mails_taken, replies_checked, frame_ends);
    $display("Mail codes rewritten %0d times; the zero-length command lockout ran last.",
             reg_writes);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/dmcs_pkg.sv
src/dmcs_front.sv
src/dmcs_queue.sv
src/dmcs_back.sv
src/dsp_mailbox_command_sync.sv
src/dmcs_checker.sv
dv/dsp_mailbox_command_sync_test.sv
